@@ design/plq_pkg.sv @@
// ----------------------------------------------------------------------------
// plq_pkg
// Shared types, constants and codes for the pooled linked queue core.
// ----------------------------------------------------------------------------
package plq_pkg;

	localparam int POOL_NODES  = 256;
	localparam int QUEUE_COUNT = 16;
	localparam int NODE_W      = $clog2(POOL_NODES);
	localparam int QID_W       = 4;
	localparam int QIDX_W      = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int PAY_W       = 48;
	localparam int HANDLE_W    = 8;
	localparam int STEP_W      = NODE_W + 1;

	typedef enum logic [1:0] {
		REQ_INIT    = 2'd0,
		REQ_ENQ     = 2'd1,
		REQ_DEQ     = 2'd2,
		REQ_CANCEL  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NO_NODES  = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		NS_FREE      = 2'd0,
		NS_QUEUED    = 2'd1,
		NS_SENTINEL  = 2'd2,
		NS_CANCELLED = 2'd3
	} nstat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_TAKE,
		S_INIT_WR,
		S_ENQ_WR,
		S_ENQ_LINK,
		S_DQ_CHECK,
		S_DQ_READ,
		S_DQ_STEP,
		S_DQ_PAY,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_req;   // capture the input item
		logic rd_free;     // read link of free_top
		logic do_take;     // pop free stack, write new node
		logic init_wr;     // finish init
		logic enq_wr;      // write enqueue node
		logic enq_link;    // link old tail to new node
		logic dq_read;     // read head's link to its successor
		logic dq_step;     // advance head, free old sentinel
		logic dq_pay;      // read payload of new sentinel
		logic cancel_wr;   // mark node cancelled
		logic set_status;  // load status register
		status_t status;
		logic clr_steps;
	} plq_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic qid_ok;
		logic q_ready;
		logic free_ok;
		logic head_is_tail;
		logic nxt_null;
		logic nxt_cancelled;
		logic steps_done;
	} plq_sts_t;

endpackage

@@ design/plq_ctrl.sv @@
// ----------------------------------------------------------------------------
// plq_ctrl
// Sequencer for queue operations: decodes the request and steps the datapath.
// ----------------------------------------------------------------------------
module plq_ctrl import plq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_free,
	output logic     busy,
	output logic     out_load,
	output plq_cmd_t cmd,
	input  plq_sts_t sts
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.status = ST_OK;
		out_load = 1'b0;
		busy     = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.latch_req = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				if (sts.req == REQ_CANCEL) begin
					cmd.cancel_wr = 1'b1;
					cmd.status = ST_OK;
					state_d = S_OUT;
				end else if (!sts.qid_ok) begin
					cmd.status = ST_NOT_READY;
					state_d = S_OUT;
				end else if (sts.req == REQ_INIT || sts.req == REQ_ENQ) begin
					if (sts.req == REQ_ENQ && !sts.q_ready) begin
						cmd.status = ST_NOT_READY;
						state_d = S_OUT;
					end else if (!sts.free_ok) begin
						cmd.status = ST_NO_NODES;
						state_d = S_OUT;
					end else begin
						cmd.rd_free = 1'b1;
						cmd.status = ST_OK;
						state_d = S_TAKE;
					end
				end else if (!sts.q_ready) begin
					cmd.status = ST_NOT_READY;
					state_d = S_OUT;
				end else begin
					cmd.status = ST_EMPTY;
					cmd.clr_steps = 1'b1;
					state_d = S_DQ_CHECK;
				end
			end
			S_TAKE: begin
				cmd.do_take = 1'b1;
				state_d = (sts.req == REQ_INIT) ? S_INIT_WR : S_ENQ_WR;
			end
			S_INIT_WR: begin
				cmd.init_wr = 1'b1;
				state_d = S_OUT;
			end
			S_ENQ_WR: begin
				cmd.enq_wr = 1'b1;
				state_d = S_ENQ_LINK;
			end
			S_ENQ_LINK: begin
				cmd.enq_link = 1'b1;
				state_d = S_OUT;
			end
			S_DQ_CHECK: begin
				if (sts.steps_done || sts.head_is_tail) begin
					state_d = S_OUT;
				end else begin
					cmd.dq_read = 1'b1;
					state_d = S_DQ_READ;
				end
			end
			S_DQ_READ: begin
				if (sts.nxt_null) begin
					state_d = S_OUT;
				end else begin
					cmd.dq_step = 1'b1;
					state_d = S_DQ_STEP;
				end
			end
			S_DQ_STEP: begin
				if (sts.nxt_cancelled) begin
					state_d = S_DQ_CHECK;
				end else begin
					cmd.dq_pay = 1'b1;
					state_d = S_DQ_PAY;
				end
			end
			S_DQ_PAY: begin
				cmd.set_status = 1'b1;
				cmd.status = ST_OK;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ design/plq_dpath.sv @@
// ----------------------------------------------------------------------------
// plq_dpath
// Node pool memories, free stack and queue pointer tables.
// ----------------------------------------------------------------------------
module plq_dpath import plq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  plq_cmd_t            cmd,
	output plq_sts_t            sts,
	input  logic [1:0]          in_req,
	input  logic [QID_W-1:0]    in_qid,
	input  logic [PAY_W-1:0]    in_payload,
	input  logic [HANDLE_W-1:0] in_handle,
	output logic [1:0]          res_status,
	output logic [PAY_W-1:0]    res_payload,
	output logic [HANDLE_W-1:0] res_node
);

	// link memory: reset pattern i -> i+1 held as valid bits
	logic [NODE_W-1:0] link_mem [POOL_NODES];
	logic [POOL_NODES-1:0] link_wr_q;
	logic [PAY_W-1:0]  pay_mem [POOL_NODES];
	// node status is always written by a take before a dequeue reads it
	logic [1:0]        nstat_mem [POOL_NODES];

	logic [NODE_W-1:0] free_top_q;
	logic [NODE_W-1:0] head_q [QUEUE_COUNT];
	logic [NODE_W-1:0] tail_q [QUEUE_COUNT];
	logic [QUEUE_COUNT-1:0] ready_q;

	req_t              req_q;
	logic [QID_W-1:0]  qid_q;
	logic [PAY_W-1:0]  pay_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [NODE_W-1:0] new_q;
	logic [NODE_W-1:0] lrd_q;
	logic              lrd_vld_q;
	logic [NODE_W-1:0] lrd_addr_q;
	logic              nxt_canc_q;
	logic [STEP_W-1:0] steps_q;
	logic [1:0]        status_q;
	logic [PAY_W-1:0]  pay_out_q;
	logic [NODE_W-1:0] node_out_q;

	logic [QIDX_W-1:0] qi;
	logic [NODE_W-1:0] cur_head;
	logic [NODE_W-1:0] rd_addr;
	logic [NODE_W-1:0] rd_link;

	assign qi       = qid_q[QIDX_W-1:0];
	assign cur_head = head_q[qi];
	assign rd_addr  = cmd.rd_free ? free_top_q : cur_head;

	// unwritten link entries hold the reset chain
	always_comb begin
		if (lrd_vld_q)
			rd_link = lrd_q;
		else
			rd_link = lrd_addr_q + NODE_W'(1);
	end

	// link memory write (one port) and registered read
	always_ff @(posedge clk) begin
		if (cmd.do_take)
			link_mem[new_q] <= '0;
		else if (cmd.enq_link)
			link_mem[tail_q[qi]] <= new_q;
		else if (cmd.dq_step)
			link_mem[cur_head] <= free_top_q;
		if (cmd.rd_free || cmd.dq_read) begin
			lrd_q      <= link_mem[rd_addr];
			lrd_vld_q  <= link_wr_q[rd_addr];
			lrd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_wr)
			pay_mem[new_q] <= pay_q;
		if (cmd.dq_pay)
			pay_out_q <= pay_mem[rd_link];
		else if (cmd.latch_req)
			pay_out_q <= '0;
	end

	// node status memory, one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.do_take)
			nstat_mem[new_q] <= (req_q == REQ_INIT) ? NS_SENTINEL : NS_QUEUED;
		else if (cmd.dq_step)
			nstat_mem[cur_head] <= NS_FREE;
		else if (cmd.cancel_wr && handle_q != '0 &&
		         {1'b0, handle_q} < (HANDLE_W+1)'(POOL_NODES))
			nstat_mem[handle_q[NODE_W-1:0]] <= NS_CANCELLED;
		if (cmd.dq_step)
			nxt_canc_q <= (nstat_mem[rd_link] == NS_CANCELLED);
	end

	// request capture and payload-free registers
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q    <= req_t'(in_req);
			qid_q    <= in_qid;
			pay_q    <= in_payload;
			handle_q <= in_handle;
		end
		if (cmd.rd_free)
			new_q <= free_top_q;
		if (cmd.set_status)
			status_q <= cmd.status;
	end

	// control state: free stack, queue tables, link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q <= NODE_W'(1);
			ready_q    <= '0;
			link_wr_q  <= '0;
			steps_q    <= '0;
			node_out_q <= '0;
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (cmd.latch_req)
				node_out_q <= '0;
			if (cmd.clr_steps)
				steps_q <= '0;
			if (cmd.do_take) begin
				free_top_q        <= rd_link;
				link_wr_q[new_q]  <= 1'b1;
				node_out_q        <= new_q;
			end
			if (cmd.init_wr) begin
				head_q[qi]  <= new_q;
				tail_q[qi]  <= new_q;
				ready_q[qi] <= 1'b1;
			end
			if (cmd.enq_link) begin
				link_wr_q[tail_q[qi]] <= 1'b1;
				tail_q[qi] <= new_q;
			end
			if (cmd.dq_step) begin
				head_q[qi]           <= rd_link;
				link_wr_q[cur_head]  <= 1'b1;
				free_top_q           <= cur_head;
				steps_q              <= steps_q + STEP_W'(1);
			end
		end
	end

	// status towards the controller
	always_comb begin
		sts.req           = req_q;
		sts.qid_ok        = ({1'b0, qid_q} < (QID_W+1)'(QUEUE_COUNT));
		sts.q_ready       = ready_q[qi];
		sts.free_ok       = (free_top_q != '0);
		sts.head_is_tail  = (cur_head == tail_q[qi]);
		sts.nxt_null      = (rd_link == '0);
		sts.nxt_cancelled = nxt_canc_q;
		sts.steps_done    = (steps_q == STEP_W'(POOL_NODES));
	end

	assign res_status  = status_q;
	assign res_payload = pay_out_q;
	assign res_node    = HANDLE_W'(node_out_q);

	// a taken node must never be null
	a_take_nonnull: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_take |-> new_q != '0) else $error("null node taken");
	// a dequeue step never frees the null node
	a_step_nonnull: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dq_step |-> cur_head != '0) else $error("null head freed");
	// after a pop the free top moved off the taken node
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_take |=> free_top_q != $past(new_q)) else $error("free top stuck");

endmodule

@@ design/pooled_linked_queue_with_cancel_core.sv @@
// ----------------------------------------------------------------------------
// pooled_linked_queue_with_cancel_core
// FIFO queues as linked lists over a shared node pool with a free stack.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tuser
// s_axis  | in  | queue_id, payload_in, cancel_handle      | req_type
// m_axis  | out | payload_out, node_handle                 | status
//
// One request at a time. Cancel and rejects go from decode straight to the output;
// init takes and writes a node, enqueue takes, writes and links one, and dequeue
// steps the head over cancelled nodes before it reads the payload of the new head.
// Results sit in an output register; a held-off result stalls the input.
// Reset is immediate; the link memory's reset chain is held by valid bits.
module pooled_linked_queue_with_cancel_core import plq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // queue_id[3:0], payload_in[51:4], cancel_handle[59:52]
	input  logic [1:0]  s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // payload_out[47:0], node_handle[55:48]
	output logic [1:0]  m_axis_tuser   // status
);

	plq_cmd_t cmd;
	plq_sts_t sts;
	logic busy, out_load, in_fire, out_free;
	logic [1:0]          r_status;
	logic [PAY_W-1:0]    r_payload;
	logic [HANDLE_W-1:0] r_node;
	logic [55:0]         odata_q;
	logic [1:0]          ouser_q;
	logic                ovalid_q;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;

	plq_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_free, .busy, .out_load, .cmd, .sts
	);

	plq_dpath u_dpath (
		.clk, .arst_n, .cmd, .sts,
		.in_req(s_axis_tuser),
		.in_qid(s_axis_tdata[3:0]),
		.in_payload(s_axis_tdata[51:4]),
		.in_handle(s_axis_tdata[59:52]),
		.res_status(r_status),
		.res_payload(r_payload),
		.res_node(r_node)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= {r_node, r_payload};
			ouser_q <= r_status;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;

endmodule
